### rtl/bba_pkg.sv
package bba_pkg;

   localparam int NUM_BLOCKS    = 1024;
   localparam int BLOCK_BYTES   = 32;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
   localparam int QUEUE_DEPTH   = 2;

   localparam int BLK_W  = 10;
   localparam int CNT_W  = 11;
   localparam int NEED_W = 12;
   localparam int SIZE_W = 16;
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int BIT_W  = $clog2(MAP_WORD_BITS);
   localparam int WORD_W = $clog2(MAP_WORDS);

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_INVALID = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LEN,
      S_GROW,
      S_CLR,
      S_SETEND,
      S_FF_FREE,
      S_FF_USED,
      S_MARK,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [BLK_W-1:0]   start;
      logic [NEED_W-1:0]  need;
      logic               zero;
   } item_type;

endpackage

### rtl/bba_front.sv
module bba_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_cmd,
   input  logic [9:0]        req_start_block,
   input  logic [15:0]       req_size_bytes,
   output bba_pkg::item_type item,
   output logic              item_valid,
   input  logic              item_pop
);
   import bba_pkg::*;

   item_type q_ff [QUEUE_DEPTH];
   item_type q_in;
   logic     wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic     push_ok, pop_ok;

   // The byte size is rounded up to whole blocks here, so the back end sees blocks only.
   always_comb begin
      q_in.cmd   = cmd_type'(req_cmd);
      q_in.start = req_start_block;
      q_in.need  = NEED_W'(req_size_bytes[SIZE_W-1:OFF_W])
                   + NEED_W'(|req_size_bytes[OFF_W-1:0]);
      q_in.zero  = (req_size_bytes == '0);
   end

   assign req_full   = (cnt_ff == 2'(QUEUE_DEPTH));
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign push_ok    = req_push & ~req_full;
   assign pop_ok     = item_pop & item_valid;

   always_comb begin
      wp_in  = push_ok ? ~wp_ff : wp_ff;
      rp_in  = pop_ok ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wp_ff] <= q_in;
      end
   end

endmodule

### rtl/bba_engine.sv
module bba_engine (
   input  logic              clock,
   input  logic              reset,
   input  bba_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_pop,
   input  logic              csr_wr_en,
   input  logic [10:0]       csr_wr_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_status,
   output logic [9:0]        rsp_result_block,
   output logic [10:0]       rsp_run_blocks,
   output logic              rsp_moved,
   output logic [10:0]       rsp_copy_blocks,
   output logic [10:0]       rsp_blocks_in_use
);
   import bba_pkg::*;

   function automatic logic [CNT_W-1:0] drop_cnt(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] n);
      return (n > c) ? '0 : c - n;
   endfunction

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [BLK_W-1:0]  start_ff, start_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              zero_ff, zero_in;
   logic [CNT_W-1:0]  len_ff, len_in, was_ff, was_in, count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in, runs_ff, runs_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]  pool_ff, pool_in;
   status_type        status_ff, status_in;
   logic [BLK_W-1:0]  rblock_ff, rblock_in;
   logic [CNT_W-1:0]  rlen_ff, rlen_in, copy_ff, copy_in;
   logic              moved_ff, moved_in;

   logic              ov_ff, ov_in;
   status_type        ostat_ff, ostat_in;
   logic [BLK_W-1:0]  oblock_ff, oblock_in;
   logic [CNT_W-1:0]  olen_ff, olen_in, ocopy_ff, ocopy_in, ocount_ff, ocount_in;
   logic              omoved_ff, omoved_in;

   logic [MAP_WORD_BITS-1:0] used_ff [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] end_ff  [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] used_in, end_in;

   logic [CNT_W-1:0]  pool_eff;
   logic [WORD_W-1:0] widx;
   logic [WORD_W:0]   w6;
   logic [MAP_WORD_BITS-1:0] used_w, end_w, src_w, from_mask, pool_mask, cand;
   logic [MAP_WORD_BITS-1:0] hi_mask, rmask, last_mask;
   logic [CNT_W-1:0]  nxt_pos, scan_res, len_c, lastp, was_tot, run_gap;
   logic [BIT_W-1:0]  hit_b;
   logic              pos_over, scan_hit, scan_done, rng_done, bad, out_free, map_we;
   logic [NEED_W-1:0] start_need;
   logic [5:0]        pop_cnt;

   assign pool_eff = (pool_ff > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : pool_ff;

   // One word of each map is looked at per cycle.
   assign widx   = (state_ff == S_CHECK) ? start_ff[BLK_W-1:BIT_W] : pos_ff[BLK_W-1:BIT_W];
   assign w6     = {1'b0, widx};
   assign used_w = used_ff[widx];
   assign end_w  = end_ff[widx];
   assign bad    = ({1'b0, start_ff} >= pool_eff) || !used_w[start_ff[BIT_W-1:0]];

   assign nxt_pos    = {w6 + 1'b1, {BIT_W{1'b0}}};
   assign from_mask  = {MAP_WORD_BITS{1'b1}} << pos_ff[BIT_W-1:0];
   assign start_need = NEED_W'(start_ff) + need_ff;

   // Scan unit: first bit of the wanted value at or after pos, below the pool end.
   always_comb begin
      hit_b = '0;
      if (state_ff == S_LEN) begin
         src_w = end_w;
      end else if (state_ff == S_FF_FREE) begin
         src_w = ~used_w;
      end else begin
         src_w = used_w;
      end
      if (pool_eff[CNT_W-1:BIT_W] > w6) begin
         pool_mask = '1;
      end else if (pool_eff[CNT_W-1:BIT_W] == w6) begin
         pool_mask = (MAP_WORD_BITS'(1) << pool_eff[BIT_W-1:0]) - MAP_WORD_BITS'(1);
      end else begin
         pool_mask = '0;
      end
      cand = src_w & pool_mask & from_mask;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) hit_b = BIT_W'(i);
      end
   end

   assign pos_over  = (pos_ff >= pool_eff);
   assign scan_hit  = !pos_over && (cand != '0);
   assign scan_done = pos_over || scan_hit || (nxt_pos >= pool_eff);
   assign scan_res  = scan_hit ? {1'b0, widx, hit_b} : pool_eff;
   assign len_c     = (scan_res - CNT_W'(start_ff)) + CNT_W'(scan_hit);
   assign run_gap   = scan_res - runs_ff;

   // Range unit: one word of [lo, hi) per cycle.
   always_comb begin
      lastp = hi_ff - 1'b1;
      if (hi_ff[CNT_W-1:BIT_W] > w6) begin
         hi_mask = '1;
      end else if (hi_ff[CNT_W-1:BIT_W] == w6) begin
         hi_mask = (MAP_WORD_BITS'(1) << hi_ff[BIT_W-1:0]) - MAP_WORD_BITS'(1);
      end else begin
         hi_mask = '0;
      end
      rmask     = from_mask & hi_mask;
      last_mask = (lastp[CNT_W-1:BIT_W] == w6) ?
                  (MAP_WORD_BITS'(1) << lastp[BIT_W-1:0]) : '0;
   end

   assign rng_done = (nxt_pos >= hi_ff);
   assign pop_cnt  = 6'($countones(used_w & rmask));
   assign was_tot  = was_ff + CNT_W'(pop_cnt);
   assign out_free = !ov_ff || rsp_pop;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if ((cmd_ff == CMD_ALLOC || cmd_ff == CMD_RESIZE) && zero_ff) begin
               state_in = S_DONE;
            end else if (cmd_ff == CMD_ALLOC) begin
               state_in = (need_ff > NEED_W'(pool_eff)) ? S_DONE : S_FF_FREE;
            end else if (bad) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (scan_done) begin
               priority if (cmd_ff == CMD_FREE) begin
                  state_in = S_CLR;
               end else if (cmd_ff != CMD_RESIZE) begin
                  state_in = S_DONE;
               end else if (need_ff == NEED_W'(len_c)) begin
                  state_in = S_DONE;
               end else if (need_ff < NEED_W'(len_c)) begin
                  state_in = S_CLR;
               end else if (start_need > NEED_W'(pool_eff)) begin
                  state_in = S_CLR;
               end else begin
                  state_in = S_GROW;
               end
            end
         end
         S_GROW: begin
            if (scan_done) state_in = (NEED_W'(scan_res) >= start_need) ? S_MARK : S_CLR;
         end
         S_CLR: begin
            if (rng_done) begin
               priority if (cmd_ff == CMD_FREE) begin
                  state_in = S_DONE;
               end else if (need_ff < NEED_W'(len_ff)) begin
                  state_in = S_SETEND;
               end else begin
                  state_in = S_FF_FREE;
               end
            end
         end
         S_SETEND: begin
            if (rng_done) state_in = S_DONE;
         end
         S_FF_FREE: begin
            if (scan_done) begin
               priority if (scan_hit) begin
                  state_in = S_FF_USED;
               end else if (cmd_ff == CMD_ALLOC) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MARK;
               end
            end
         end
         S_FF_USED: begin
            if (scan_done) state_in = (NEED_W'(run_gap) >= need_ff) ? S_MARK : S_FF_FREE;
         end
         S_MARK: begin
            if (rng_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      cmd_in = cmd_ff;   start_in = start_ff; need_in = need_ff; zero_in = zero_ff;
      len_in = len_ff;   was_in = was_ff;     count_in = count_ff;
      pos_in = pos_ff;   runs_in = runs_ff;   lo_in = lo_ff;     hi_in = hi_ff;
      status_in = status_ff; rblock_in = rblock_ff; rlen_in = rlen_ff;
      moved_in = moved_ff;   copy_in = copy_ff;
      pool_in  = csr_wr_en ? csr_wr_data : pool_ff;
      item_pop = 1'b0;
      map_we   = 1'b0;
      used_in  = used_w;
      end_in   = end_w;
      ov_in = ov_ff; ostat_in = ostat_ff; oblock_in = oblock_ff; olen_in = olen_ff;
      omoved_in = omoved_ff; ocopy_in = ocopy_ff; ocount_in = ocount_ff;
      if (rsp_pop) ov_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop  = 1'b1;
               cmd_in    = item.cmd;
               start_in  = item.start;
               need_in   = item.need;
               zero_in   = item.zero;
               status_in = ST_OK;
               rblock_in = '0;
               rlen_in   = '0;
               moved_in  = 1'b0;
               copy_in   = '0;
               was_in    = '0;
            end
         end
         S_CHECK: begin
            pos_in = (cmd_ff == CMD_ALLOC) ? '0 : CNT_W'(start_ff);
            priority if ((cmd_ff == CMD_ALLOC || cmd_ff == CMD_RESIZE) && zero_ff) begin
               status_in = ST_ZERO;
            end else if (cmd_ff == CMD_ALLOC) begin
               if (need_ff > NEED_W'(pool_eff)) status_in = ST_NOSPACE;
            end else if (bad) begin
               status_in = ST_INVALID;
            end
         end
         S_LEN: begin
            if (!scan_done) begin
               pos_in = nxt_pos;
            end else begin
               len_in    = len_c;
               rblock_in = start_ff;
               rlen_in   = len_c;
               lo_in     = CNT_W'(start_ff);
               hi_in     = CNT_W'(start_ff) + len_c;
               pos_in    = CNT_W'(start_ff);
               if (cmd_ff == CMD_RESIZE) begin
                  if (need_ff < NEED_W'(len_c)) begin
                     // Shrink: release the tail of the run.
                     lo_in   = CNT_W'(start_need);
                     pos_in  = CNT_W'(start_need);
                     rlen_in = CNT_W'(need_ff);
                  end else if (need_ff > NEED_W'(len_c) &&
                               start_need <= NEED_W'(pool_eff)) begin
                     pos_in = CNT_W'(start_ff) + len_c;
                  end
               end
            end
         end
         S_GROW: begin
            if (!scan_done) begin
               pos_in = nxt_pos;
            end else begin
               lo_in  = CNT_W'(start_ff);
               pos_in = CNT_W'(start_ff);
               if (NEED_W'(scan_res) >= start_need) begin
                  hi_in    = CNT_W'(start_need);
                  count_in = count_ff + CNT_W'(need_ff - NEED_W'(len_ff));
                  rlen_in  = CNT_W'(need_ff);
               end else begin
                  hi_in = CNT_W'(start_ff) + len_ff;
               end
            end
         end
         S_CLR: begin
            map_we  = 1'b1;
            used_in = used_w & ~rmask;
            end_in  = end_w & ~rmask;
            was_in  = was_tot;
            if (!rng_done) begin
               pos_in = nxt_pos;
            end else if (cmd_ff == CMD_FREE) begin
               count_in = drop_cnt(count_ff, was_tot);
            end else if (need_ff < NEED_W'(len_ff)) begin
               count_in = drop_cnt(count_ff, was_tot);
               lo_in    = CNT_W'(start_need) - 1'b1;
               hi_in    = CNT_W'(start_need);
               pos_in   = CNT_W'(start_need) - 1'b1;
            end else begin
               pos_in = '0;
            end
         end
         S_SETEND: begin
            map_we = 1'b1;
            end_in = end_w | last_mask;
         end
         S_FF_FREE: begin
            if (!scan_done) begin
               pos_in = nxt_pos;
            end else if (scan_hit) begin
               runs_in = scan_res;
               pos_in  = scan_res;
            end else begin
               status_in = ST_NOSPACE;
               if (cmd_ff == CMD_RESIZE) begin
                  // Put the old run back where it was.
                  lo_in  = CNT_W'(start_ff);
                  hi_in  = CNT_W'(start_ff) + len_ff;
                  pos_in = CNT_W'(start_ff);
               end
            end
         end
         S_FF_USED: begin
            if (!scan_done) begin
               pos_in = nxt_pos;
            end else if (NEED_W'(run_gap) >= need_ff) begin
               lo_in     = runs_ff;
               hi_in     = runs_ff + CNT_W'(need_ff);
               pos_in    = runs_ff;
               rblock_in = runs_ff[BLK_W-1:0];
               rlen_in   = CNT_W'(need_ff);
               if (cmd_ff == CMD_ALLOC) begin
                  count_in = count_ff + CNT_W'(need_ff);
               end else begin
                  count_in = drop_cnt(count_ff, was_ff) + CNT_W'(need_ff);
                  moved_in = 1'b1;
                  copy_in  = len_ff;
               end
            end else begin
               pos_in = scan_res;
            end
         end
         S_MARK: begin
            map_we  = 1'b1;
            used_in = used_w | rmask;
            end_in  = (end_w & ~rmask) | last_mask;
            if (!rng_done) pos_in = nxt_pos;
         end
         S_DONE: begin
            if (out_free) begin
               ov_in     = 1'b1;
               ostat_in  = status_ff;
               oblock_in = rblock_ff;
               olen_in   = rlen_ff;
               omoved_in = moved_ff;
               ocopy_in  = copy_ff;
               ocount_in = count_ff;
            end
         end
         default: begin
            ov_in = ov_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pool_ff  <= CNT_W'(NUM_BLOCKS);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pool_ff  <= pool_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;    start_ff  <= start_in;  need_ff   <= need_in;
      zero_ff   <= zero_in;   len_ff    <= len_in;    was_ff    <= was_in;
      pos_ff    <= pos_in;    runs_ff   <= runs_in;   lo_ff     <= lo_in;
      hi_ff     <= hi_in;     status_ff <= status_in; rblock_ff <= rblock_in;
      rlen_ff   <= rlen_in;   moved_ff  <= moved_in;  copy_ff   <= copy_in;
      ostat_ff  <= ostat_in;  oblock_ff <= oblock_in; olen_ff   <= olen_in;
      omoved_ff <= omoved_in; ocopy_ff  <= ocopy_in;  ocount_ff <= ocount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_WORDS; i++) begin
            used_ff[i] <= '0;
            end_ff[i]  <= '0;
         end
      end else if (map_we) begin
         used_ff[widx] <= used_in;
         end_ff[widx]  <= end_in;
      end
   end

   assign rsp_empty         = !ov_ff;
   assign rsp_status        = ostat_ff;
   assign rsp_result_block  = oblock_ff;
   assign rsp_run_blocks    = olen_ff;
   assign rsp_moved         = omoved_ff;
   assign rsp_copy_blocks   = ocopy_ff;
   assign rsp_blocks_in_use = ocount_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_BLOCKS))
      else $error("allocated count beyond the pool size");

   a_write_in_pool: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (pos_ff < pool_eff))
      else $error("bitmap write outside the pool");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(ov_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside the completion state");

endmodule

### rtl/bitmap_block_allocator_unit.sv
// Channel   Ports                          Direction  Handshake
// request   req_cmd/start_block/size_bytes in         req_push, req_full
// response  rsp_status ... rsp_blocks_in_use out      rsp_pop, rsp_empty
// config    csr_wr_data (pool_blocks)      in         csr_wr_en
//
// A two-entry request queue feeds a sequencer that works on one 32-bit bitmap word per cycle.
// Each item walks the bitmap word by word for the run length, for clearing and for marking,
// and the first-fit search tries free runs in turn, skipping words that hold no candidate.
// A search of a fragmented 1024-block pool takes longer than a search of an empty one.
// Synchronous reset clears both bitmaps at once; the block accepts items right after reset.
// A result not taken holds the sequencer; the request queue fills its two entries meanwhile.
module bitmap_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_start_block,
   input  logic [15:0] req_size_bytes,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_result_block,
   output logic [10:0] rsp_run_blocks,
   output logic        rsp_moved,
   output logic [10:0] rsp_copy_blocks,
   output logic [10:0] rsp_blocks_in_use,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);
   import bba_pkg::*;

   item_type item;
   logic     item_valid, item_pop;

   bba_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_start_block (req_start_block),
      .req_size_bytes  (req_size_bytes),
      .item            (item),
      .item_valid      (item_valid),
      .item_pop        (item_pop)
   );

   bba_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .item              (item),
      .item_valid        (item_valid),
      .item_pop          (item_pop),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_result_block  (rsp_result_block),
      .rsp_run_blocks    (rsp_run_blocks),
      .rsp_moved         (rsp_moved),
      .rsp_copy_blocks   (rsp_copy_blocks),
      .rsp_blocks_in_use (rsp_blocks_in_use)
   );

endmodule
